// ===== rtl/dpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfl_pkg: shared definitions for the distinct prime factor lister
// Widths, result codes and the request/response bundles of the divider.
// ----------------------------------------------------------------------------
package dpfl_pkg;

  // Input word width, two's complement
  localparam int VALUE_WIDTH = 32;
  // Magnitude of a positive input
  localparam int N_W = VALUE_WIDTH - 1;
  // Trial divisor width: holds floor(sqrt(max n)) + 1
  localparam int D_W = N_W / 2 + 1;
  // Square of a trial divisor
  localparam int SQ_W = 2 * D_W;
  // Result factor field
  localparam int FACTOR_W = 31;
  // Listing stops after this many results
  localparam int MAX_RESULTS = 9;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic           start;
    logic [N_W-1:0] dividend;
    logic [D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] quotient;
    logic [D_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/dpfl_in_if.sv =====
// ----------------------------------------------------------------------------
// dpfl_in_if: input request channel
// Valid/ready handshake carrying one signed value to factor.
// ----------------------------------------------------------------------------
interface dpfl_in_if;
  import dpfl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/dpfl_out_if.sv =====
// ----------------------------------------------------------------------------
// dpfl_out_if: result request channel
// Valid/ready handshake carrying one prime factor, a status code and last.
// ----------------------------------------------------------------------------
interface dpfl_out_if;
  import dpfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [FACTOR_W-1:0] prime_factor;
  logic [1:0]          status;
  logic                last;

  modport source (output valid, output prime_factor, output status, output last,
                  input ready);
  modport sink   (input valid, input prime_factor, input status, input last,
                  output ready);
endinterface

// ===== rtl/dpfl_div.sv =====
// ----------------------------------------------------------------------------
// dpfl_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses in the same cycle that the final quotient and remainder appear.
// ----------------------------------------------------------------------------
module dpfl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dpfl_pkg::div_req_t req,
  output dpfl_pkg::div_rsp_t rsp
);
  import dpfl_pkg::*;

  localparam int CW = $clog2(N_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(N_W - 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [N_W-1:0] q_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] dvs_r;

  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           take;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, q_r[N_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[N_W-2:0], take};
      rem_r <= take ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/distinct_prime_factor_lister.sv =====
// ----------------------------------------------------------------------------
// distinct_prime_factor_lister: trial-division prime factor lister
// Lists the distinct prime divisors of a signed input in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one signed value per request; out_ch returns one request
//   per distinct prime, ascending, with last set on the final one. A zero
//   input returns one request with status bad-input; one or a negative input
//   returns one request with status no-factors. prime_factor is zero then.
// Timing:
//   Zero, one and negative inputs: the result is registered the cycle after
//   acceptance. Otherwise every trial divisor d from 2 up to sqrt(n) costs a
//   square, a compare and a 31-step remainder in the single restoring
//   divider plus its done pulse; each extra division by a found prime costs
//   another such remainder. Worst case near 46341 divisors per input. The
//   divider sets the rate.
//   in_ch.ready is high only while the sequencer is idle, one input at a time.
// Reset and stall:
//   rst_n (synchronous, active low) returns the sequencer to idle and drops
//   any pending result. A stalled receiver holds the output register; the
//   search halts at the next found prime until the slot frees up.
// ----------------------------------------------------------------------------
module distinct_prime_factor_lister (
  input  logic              clk,
  input  logic              rst_n,
  dpfl_in_if.sink           in_ch,
  dpfl_out_if.source        out_ch
);
  import dpfl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_FOUND = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_LAST  = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [N_W-1:0]  n_r, n_nxt;         // cofactor still to be factored
  logic [D_W-1:0]  d_r, d_nxt;         // current trial divisor
  logic [SQ_W-1:0] sq_r, sq_nxt;       // d squared
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [N_W-1:0]  pend_r, pend_nxt;   // held prime, last not yet known
  logic            pend_v_r, pend_v_nxt;
  logic            found_r, found_nxt; // d divided n at least once

  logic                out_valid_r;
  logic [FACTOR_W-1:0] out_factor_r;
  status_t             out_status_r;
  logic                out_last_r;

  logic                slot_free;
  logic                put_en;
  logic [FACTOR_W-1:0] put_factor;
  status_t             put_status;
  logic                put_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dpfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // output register accepts a new request when empty or being drained
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    count_nxt        = count_r;
    pend_nxt         = pend_r;
    pend_v_nxt       = pend_v_r;
    found_nxt        = found_r;
    put_en           = 1'b0;
    put_factor       = '0;
    put_status       = ST_OK;
    put_last         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = n_r;
    div_req.divisor  = d_r;
    in_ch.ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = slot_free;
        if (in_ch.valid && slot_free) begin
          priority if (in_ch.value == '0) begin
            put_en     = 1'b1;
            put_status = ST_BAD;
            put_last   = 1'b1;
          end else if (in_ch.value[VALUE_WIDTH-1] || in_ch.value == VALUE_WIDTH'(1)) begin
            put_en     = 1'b1;
            put_status = ST_NONE;
            put_last   = 1'b1;
          end else begin
            n_nxt      = in_ch.value[N_W-1:0];
            d_nxt      = D_W'(2);
            count_nxt  = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_SQ;
          end
        end
      end
      S_SQ: begin
        sq_nxt    = d_r * d_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // continue while d*d <= n and the result budget is not spent
        if ({{(SQ_W-N_W){1'b0}}, n_r} >= sq_r && count_r < CNT_W'(MAX_RESULTS)) begin
          div_req.start = 1'b1;
          found_nxt     = 1'b0;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            // divide out and try the same divisor again
            n_nxt            = div_rsp.quotient;
            found_nxt        = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end else if (found_r) begin
            state_nxt = S_FOUND;
          end else begin
            d_nxt     = d_r + D_W'(1);
            state_nxt = S_SQ;
          end
        end
      end
      S_FOUND: begin
        // release the held prime, hold the new one until its successor shows
        if (!pend_v_r || slot_free) begin
          put_en     = pend_v_r;
          put_factor = FACTOR_W'(pend_r);
          pend_nxt   = N_W'(d_r);
          pend_v_nxt = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          d_nxt      = d_r + D_W'(1);
          state_nxt  = S_SQ;
        end
      end
      S_TAIL: begin
        // a cofactor above one is the largest prime
        if (n_r > N_W'(1) && count_r < CNT_W'(MAX_RESULTS)) begin
          if (!pend_v_r || slot_free) begin
            put_en     = pend_v_r;
            put_factor = FACTOR_W'(pend_r);
            pend_nxt   = n_r;
            pend_v_nxt = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
            state_nxt  = S_LAST;
          end
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (slot_free) begin
          put_en     = 1'b1;
          put_factor = FACTOR_W'(pend_r);
          put_last   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      n_r      <= '0;
      d_r      <= '0;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      d_r      <= d_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    pend_r <= pend_nxt;
  end

  // output register: load on put, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      out_factor_r <= put_factor;
      out_status_r <= put_status;
      out_last_r   <= put_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.prime_factor = out_factor_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.last         = out_last_r;

  // divider answers only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider done outside division wait");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond limit");

  a_zero_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.value == '0)
      |=> (out_valid_r && out_status_r == ST_BAD && out_last_r))
    else $error("zero input did not give bad-input status");

  a_ok_factor_prime_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK) |-> out_factor_r >= FACTOR_W'(2))
    else $error("factor below two reported");

  a_div_trial_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> d_r >= D_W'(2))
    else $error("trial divisor below two");

endmodule
